// File: hdl/bdq_pkg.sv
// bdq_pkg: shared types and constants for the bounded deque block
// operation and status codes, controller-to-datapath command and status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int FILL_W   = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_DEL_POS   = 3'd4,
    OP_READ      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;   // run the accepted command and load its first result
    logic step;   // load the next read-out word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;   // result in the output register is the final one
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/bdq_ctrl.sv
// bdq_ctrl: handshake controller for the bounded deque
// owns the output valid and issues exec/step commands to bdq_dp
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_BUSY;
      end
      S_BUSY: begin
        // a final beat leaving while nothing new comes in drains the block
        if (out_fire && sts.last && !in_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_BUSY: begin
        out_tvalid = 1'b1;
        // the output register frees up this cycle, so the next item may load
        in_tready  = out_tready && sts.last;
      end
      default: begin
        in_tready  = 1'b0;
        out_tvalid = 1'b0;
      end
    endcase
    cmd.exec = in_tvalid && in_tready;
    cmd.step = out_tvalid && out_tready && !sts.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bdq_dp.sv
// bdq_dp: shifting register chain, element count and output register
// read out rotates the chain one place per beat, restoring it at the end
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_dp
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_cmd_t             cmd,
  input  wire logic [OP_W-1:0]     op_in,
  input  wire logic [VALUE_W-1:0]  value_in,
  input  wire logic [POS_W-1:0]    pos_in,
  output dp_sts_t                  sts,
  output logic [STATUS_W-1:0]      status_out,
  output logic [WORD_W-1:0]        word_out,
  output logic                     last_out,
  output logic [FILL_W-1:0]        fill_out
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] ent_r [DEPTH];
  logic [DATA_WIDTH-1:0] ent_nxt [DEPTH];
  logic [CW-1:0]         cnt_r, cnt_nxt, rd_r, rd_nxt;
  status_t               status_r, status_nxt;
  logic [WORD_W-1:0]     word_r, word_nxt;
  logic                  last_r, last_nxt;

  op_t                   op;
  logic signed [63:0]    v_wide;
  logic [DATA_WIDTH-1:0] v_ext;
  logic [63:0]           head_wide;
  logic [CW-1:0]         cnt_m1;
  logic [FILL_W-1:0]     cnt_fill, pos_m1;
  logic                  full, empty, pos_ok;

  // chain controls
  logic                  shl_en, wrap_en, ins_front_en, ins_back_en;
  logic [FILL_W-1:0]     shl_from;

  assign op        = op_t'(op_in);
  assign v_wide    = 64'(signed'(value_in));
  assign v_ext     = v_wide[DATA_WIDTH-1:0];
  assign head_wide = 64'(ent_r[0]);
  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_fill  = FILL_W'(cnt_r);
  assign pos_m1    = pos_in - FILL_W'(1);
  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign pos_ok    = (pos_in != '0) && (pos_in <= cnt_fill);

  always_comb begin
    cnt_nxt      = cnt_r;
    rd_nxt       = rd_r;
    status_nxt   = status_r;
    word_nxt     = word_r;
    last_nxt     = last_r;
    shl_en       = 1'b0;
    wrap_en      = 1'b0;
    ins_front_en = 1'b0;
    ins_back_en  = 1'b0;
    shl_from     = '0;
    if (cmd.exec) begin
      status_nxt = ST_OK;
      word_nxt   = '0;
      last_nxt   = 1'b1;
      rd_nxt     = '0;
      case (op)
        OP_INS_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ins_front_en = 1'b1;
            cnt_nxt      = cnt_r + CW'(1);
          end
        end
        OP_INS_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ins_back_en = 1'b1;
            cnt_nxt     = cnt_r + CW'(1);
          end
        end
        OP_DEL_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            shl_en  = 1'b1;
            cnt_nxt = cnt_m1;
          end
        end
        OP_DEL_BACK: begin
          if (empty) status_nxt = ST_EMPTY;
          else       cnt_nxt    = cnt_m1;
        end
        OP_DEL_POS: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (!pos_ok) begin
            status_nxt = ST_BADPOS;
          end else begin
            shl_en   = 1'b1;
            shl_from = pos_m1;
            cnt_nxt  = cnt_m1;
          end
        end
        OP_READ: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            word_nxt = head_wide[WORD_W-1:0];
            last_nxt = (cnt_r == CW'(1));
            rd_nxt   = cnt_m1;
            shl_en   = 1'b1;
            wrap_en  = 1'b1;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end else if (cmd.step) begin
      status_nxt = ST_OK;
      word_nxt   = head_wide[WORD_W-1:0];
      last_nxt   = (rd_r == CW'(1));
      rd_nxt     = rd_r - CW'(1);
      shl_en     = 1'b1;
      wrap_en    = 1'b1;
    end
  end

  // per-entry next value of the chain
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (ins_front_en) begin
      ent_nxt[0] = v_ext;
      for (int i = 1; i < DEPTH; i++) begin
        ent_nxt[i] = ent_r[i-1];
      end
    end
    if (ins_back_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CW'(i) == cnt_r) ent_nxt[i] = v_ext;
      end
    end
    if (shl_en) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (FILL_W'(i) >= shl_from) ent_nxt[i] = ent_r[i+1];
      end
    end
    // rotation: the head moves behind the last stored word
    if (wrap_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CW'(i) == cnt_m1) ent_nxt[i] = ent_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
    status_r <= status_nxt;
    word_r   <= word_nxt;
    last_r   <= last_nxt;
  end

  assign sts.last   = last_r;
  assign status_out = status_r;
  assign word_out   = word_r;
  assign last_out   = last_r;
  assign fill_out   = cnt_fill;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.step))
    else $error("exec and step in the same cycle");

  a_step_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (rd_r != '0))
    else $error("read-out step with no words left");

  a_rd_vs_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_r != '0) |-> !last_r)
    else $error("words left but final beat flagged");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (cnt_r == $past(cnt_r)))
    else $error("count changed during read out");
`endif

endmodule

`default_nettype wire

// File: hdl/bounded_deque_with_positional_delete.sv
// bounded_deque_with_positional_delete: top level of the bounded deque
// wires the controller bdq_ctrl to the datapath bdq_dp
// depends on bdq_pkg, bdq_ctrl, bdq_dp
//
// usage:
//   in channel takes one command per beat: insert front/back, delete
//   front/back/at a 1-based position, or read out.
//   out channel returns results; status travels in out_tuser, the final
//   beat caused by a command carries out_tlast.
//   every command but read out gives one beat, in the cycle after it is
//   taken; with out_tready held high these commands run at one per cycle,
//   since a new command loads while the previous result leaves.
//   read out of n stored words gives n beats front first, one per cycle if
//   not stalled; the chain rotates one place per beat, so the next command
//   is taken only together with the final beat. an empty read out gives one
//   beat. the head of the chain is the only tap the output reads.
//   reset empties the list at once; no clearing pass is needed.
//   when the receiver stalls, the result beat holds and no new command is
//   taken until it leaves.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_positional_delete
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // operation[2:0], value[34:3], position[41:35], zero[47:42]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // word[31:0], fill[38:32], zero[39]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]         out_tuser,
  output logic                        out_tlast
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [WORD_W-1:0] word;
  logic [FILL_W-1:0] fill;

  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bdq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .op_in      (in_tdata[OP_W-1:0]),
    .value_in   (in_tdata[OP_W+VALUE_W-1:OP_W]),
    .pos_in     (in_tdata[OP_W+VALUE_W+POS_W-1:OP_W+VALUE_W]),
    .sts        (sts),
    .status_out (out_tuser),
    .word_out   (word),
    .last_out   (out_tlast),
    .fill_out   (fill)
  );

  assign out_tdata = OUT_TDATA_W'({fill, word});

endmodule

`default_nettype wire

// File: test/bounded_deque_with_positional_delete_tb.sv
// bounded_deque_with_positional_delete_tb: self-checking bench for the bounded deque
// drives command beats with bursty timing, tracks the list contents in a queue and
// checks every result beat against it; depends on bdq_pkg and the top level only
`timescale 1ns / 1ps

module bounded_deque_with_positional_delete_tb;
  import bdq_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int PAD_W = IN_TDATA_W - OP_W - VALUE_W - POS_W;
  localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
  localparam int MAX_REPORTS = 40;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;
  typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   word;
    logic                last;
    logic [FILL_W-1:0]   fill;
  } beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;

  // list contents as the block should hold them, front at index 0
  logic [WORD_W-1:0] list_words[$];
  // result beats still owed by the block, oldest first
  beat_t beats_due[$];

  int errors = 0;
  int cmds_sent = 0;
  int beats_checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_badpos = 0;
  int n_readouts = 0;
  int burst_left = 0;
  int stall_tick = 0;
  rx_mode_t rx_mode = RX_STEADY;
  beat_t want;
  beat_t got;

  always #5 clk = ~clk;

  bounded_deque_with_positional_delete #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (WORD_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // receiver: switches at random between stall patterns
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 255) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_STEADY:   out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= (stall_tick % 7 != 3) && (stall_tick % 7 != 4);
      default:     out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic owe_beat(input logic [STATUS_W-1:0] status, input logic [WORD_W-1:0] word,
                          input logic last);
    beat_t b;
    b.status = status;
    b.word   = word;
    b.last   = last;
    b.fill   = FILL_W'(list_words.size());
    beats_due.push_back(b);
  endtask

  // update the list for one accepted command and queue the beats it owes
  task automatic apply_command(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    int n;
    n = list_words.size();
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (n >= LIST_DEPTH) begin
          n_full++;
          owe_beat(ST_FULL, '0, 1'b1);
        end else begin
          if (op == OP_INS_FRONT) list_words.push_front(val);
          else list_words.push_back(val);
          owe_beat(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
        if (n == 0) begin
          n_empty++;
          owe_beat(ST_EMPTY, '0, 1'b1);
        end else if (op == OP_DEL_POS && (pos < 1 || pos > n)) begin
          n_badpos++;
          owe_beat(ST_BADPOS, '0, 1'b1);
        end else begin
          if (op == OP_DEL_FRONT) void'(list_words.pop_front());
          else if (op == OP_DEL_BACK) void'(list_words.pop_back());
          else list_words.delete(pos - 1);
          owe_beat(ST_OK, '0, 1'b1);
        end
      end
      OP_READ: begin
        n_readouts++;
        if (n == 0) begin
          n_empty++;
          owe_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            owe_beat(ST_OK, list_words[i], (i == n - 1));
          end
        end
      end
      default: owe_beat(ST_OK, '0, 1'b1);
    endcase
  endtask

  // one command beat; opens a new burst after a random gap when the last one ran out
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, pos, val, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_command(op, val, pos);
    cmds_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.status = out_tuser;
      got.word   = out_tdata[WORD_W-1:0];
      got.last   = out_tlast;
      got.fill   = out_tdata[WORD_W +: FILL_W];
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat status=%0d word=%h last=%b fill=%0d",
                   $time, got.status, got.word, got.last, got.fill);
      end else begin
        want = beats_due.pop_front();
        beats_checked++;
        if (got.status !== want.status || got.word !== want.word ||
            got.last !== want.last || got.fill !== want.fill) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: mismatch expected status=%0d word=%h last=%b fill=%0d,",
                     $time, want.status, want.word, want.last, want.fill);
            $display("%0t:   actual status=%0d word=%h last=%b fill=%0d",
                     $time, got.status, got.word, got.last, got.fill);
          end
        end
      end
    end
  end

  // every delete kind and the read out on an empty list, plus the unused codes
  task automatic test_empty_list();
    send_cmd(OP_READ, '0, '0);
    send_cmd(OP_DEL_FRONT, '0, 7'd1);
    send_cmd(OP_DEL_BACK, '1, 7'd0);
    send_cmd(OP_DEL_POS, '0, 7'd64);
    send_cmd(OP_UNUSED_A, 32'h7fff_ffff, 7'd3);
    send_cmd(OP_UNUSED_B, 32'h8000_0000, 7'd64);
  endtask

  // fill from both ends with extreme words, push past full, read the whole list
  task automatic test_full_list();
    logic [VALUE_W-1:0] edge_words[6];
    logic [VALUE_W-1:0] v;
    edge_words = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
                   32'h5555_5555, 32'haaaa_aaaa};
    for (int i = 0; i < LIST_DEPTH; i++) begin
      v = (i < 6) ? edge_words[i] : $urandom;
      send_cmd((i % 2 == 0) ? OP_INS_FRONT : OP_INS_BACK, v, 7'(i));
    end
    send_cmd(OP_INS_FRONT, 32'h1234_5678, '0);
    send_cmd(OP_INS_BACK, 32'h8765_4321, '0);
    send_cmd(OP_READ, '0, '0);
  endtask

  // positions out of range on both sides, then the back, front and a middle one
  task automatic test_positional_delete();
    send_cmd(OP_DEL_POS, '0, 7'd0);
    send_cmd(OP_DEL_POS, '0, 7'(LIST_DEPTH + 1));
    send_cmd(OP_DEL_POS, '0, 7'(LIST_DEPTH));
    send_cmd(OP_DEL_POS, '0, 7'd1);
    send_cmd(OP_DEL_POS, '1, 7'd7);
    send_cmd(OP_READ, '0, '0);
  endtask

  // random segments that lean toward growing, shrinking or neither
  task automatic test_random_mix(input int n_items);
    mix_t mix;
    int seg_left;
    int ins_w;
    int del_w;
    int r;
    int n;
    logic [OP_W-1:0] op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0] pos;
    seg_left = 0;
    mix = MIX_EVEN;
    for (int k = 0; k < n_items; k++) begin
      if (seg_left == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(10, 30);
      end
      seg_left--;
      ins_w = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 15 : 45;
      del_w = (mix == MIX_GROW) ? 18 : (mix == MIX_SHRINK) ? 73 : 43;
      r = $urandom_range(0, 99);
      if (r < ins_w) op = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
      else if (r < ins_w + del_w) begin
        case ($urandom_range(0, 3))
          0: op = OP_DEL_FRONT;
          1: op = OP_DEL_BACK;
          default: op = OP_DEL_POS;
        endcase
      end
      else if (r < 97) op = OP_READ;
      else op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;

      case ($urandom_range(0, 9))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
        default: val = $urandom;
      endcase

      n = list_words.size();
      r = $urandom_range(0, 99);
      if (op != OP_DEL_POS) pos = POS_W'($urandom_range(0, 64));
      else if (r < 75 && n > 0) pos = POS_W'($urandom_range(1, n));
      else if (r < 83) pos = 7'd0;
      else if (r < 92) pos = POS_W'($urandom_range(n + 1, 64));
      else pos = 7'd64;
      send_cmd(op, val, pos);
    end
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    while (beats_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_full_list();
    test_positional_delete();
    test_random_mix(240);
    in_tvalid <= 1'b0;
    wait_for_results();
    if (beats_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, beats_due.size());
    end
    $display("run covered %0d commands and %0d result beats, %0d read outs", cmds_sent,
             beats_checked, n_readouts);
    $display("full inserts %0d, empty-list hits %0d, bad positions %0d, errors %0d",
             n_full, n_empty, n_badpos, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
hdl/bdq_pkg.sv
hdl/bdq_ctrl.sv
hdl/bdq_dp.sv
hdl/bounded_deque_with_positional_delete.sv
test/bounded_deque_with_positional_delete_tb.sv
